// File: hw/rtl/interval_timeline_labeler_assert.svh
// ----------------------------------------------------------------------------
// Interval timeline labeler assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_TIMELINE_LABELER_ASSERT_SVH
`define INTERVAL_TIMELINE_LABELER_ASSERT_SVH

`ifndef SYNTHESIS
// Checked on every rising clock edge outside of reset.
`define ITL_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("interval_timeline_labeler: assertion failed");
// Checked on every rising clock edge, reset included.
`define ITL_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("interval_timeline_labeler: assertion failed");
`else
`define ITL_ASSERT(lbl, prop)
`define ITL_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: hw/rtl/itl_pkg.sv
// ----------------------------------------------------------------------------
// Interval timeline labeler package
// Shared types and codes for the labeler and its compare unit.
// ----------------------------------------------------------------------------
package itl_pkg;

	localparam int TIME_W  = 64;
	localparam int LABEL_W = 32;

	// Input kinds carried on the slave-side tuser.
	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_LOAD  = 2'd1;
	localparam logic [1:0] ACT_QUERY = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_INVALID  = 2'd1;
	localparam logic [1:0] STAT_OVERFLOW = 2'd2;

	localparam logic [TIME_W-1:0]  SIGN_TIME  = {1'b1, {(TIME_W-1){1'b0}}};
	localparam logic [LABEL_W-1:0] SIGN_LABEL = {1'b1, {(LABEL_W-1){1'b0}}};

	// One stored interval, raw signed values.
	typedef struct packed {
		logic [TIME_W-1:0]  start_time;
		logic [TIME_W-1:0]  end_time;
		logic [LABEL_W-1:0] label;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Verdict of the compare unit for one table entry.
	typedef struct packed {
		logic covers;
		logic greater;
		logic take;
	} cmp_res_t;

endpackage

// File: hw/rtl/interval_timeline_labeler.sv
// ----------------------------------------------------------------------------
// Interval timeline labeler
// Labels query timestamps with the greatest covering stored interval.
// ----------------------------------------------------------------------------
// Usage: each slave-side transfer carries a kind on s_tuser (clear, load or
// query) and the interval or timestamp on s_tdata. A load appends an interval
// to the table, a clear empties it, and neither produces a result. A query
// produces exactly one master-side transfer: the label on m_tdata, and the
// covered flag and status on m_tuser. The default label is written through
// cfg_we / cfg_wdata, by the user only while the block is idle (not enforced).
// Timing: clear and load are handled in the idle state. A query scans the table
// one entry per cycle through a single compare unit fed from the table RAM,
// visiting all N stored entries (N up to MAX_INTERVALS); it skips the scan
// when the table is empty or an invalid interval has been loaded. The block
// takes no new transfer while a query is in flight.
// Stall: the result sits in an output register; new loads and clears are still
// taken while it waits, and a following query holds at its end until the
// receiver takes the previous result.
// Reset: the table becomes empty, both sticky flags clear, the default label
// returns to zero and no result is pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
`include "interval_timeline_labeler_assert.svh"

module interval_timeline_labeler #(
	parameter int MAX_INTERVALS = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration: default label.
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata,
	// Slave side.
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tdata fields from bit 0: interval_start[63:0], interval_end[127:64],
	// interval_label[159:128], query_time[223:160].
	input  logic [223:0] s_tdata,
	// s_tuser fields from bit 0: action[1:0].
	input  logic [1:0]   s_tuser,
	// Master side.
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata fields from bit 0: label[31:0].
	output logic [31:0]  m_tdata,
	// m_tuser fields from bit 0: covered[0], status[2:1].
	output logic [2:0]   m_tuser
);

	import itl_pkg::*;

	localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
	localparam int CW = $clog2(MAX_INTERVALS + 1);

	// Sequencer states.
	localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a transfer
	localparam logic [1:0] ST_SCAN = 2'd1;  // issuing table reads
	localparam logic [1:0] ST_LAST = 2'd2;  // last read data under compare
	localparam logic [1:0] ST_FIN  = 2'd3;  // result ready for the output register

	logic [1:0]          state_q;
	logic [CW-1:0]       count_q;
	logic                inv_q;
	logic                ovf_q;
	logic [LABEL_W-1:0]  default_q;
	logic [TIME_W-1:0]   t_q;
	logic [AW-1:0]       addr_q;
	logic                rd_valid_s1;
	entry_t              best_q;
	logic                found_q;

	logic                m_tvalid_q;
	logic [LABEL_W-1:0]  m_label_q;
	logic                m_covered_q;
	logic [1:0]          m_status_q;

	// Unpack the slave-side fields.
	entry_t              in_entry;
	logic [TIME_W-1:0]   in_query_time;
	logic [1:0]          in_action;
	logic                accept;
	logic                table_full;
	logic                last_addr;
	logic                out_load;

	entry_t              rd_entry;
	logic [ENTRY_W-1:0]  rd_data;
	cmp_res_t            cmp_res;
	logic                ram_we;

	assign in_entry.start_time = s_tdata[63:0];
	assign in_entry.end_time   = s_tdata[127:64];
	assign in_entry.label      = s_tdata[159:128];
	assign in_query_time       = s_tdata[223:160];
	assign in_action           = s_tuser;

	assign s_tready   = (state_q == ST_IDLE);
	assign accept     = s_tvalid && s_tready;
	assign table_full = (count_q == CW'(MAX_INTERVALS));
	assign last_addr  = ((CW'(addr_q) + CW'(1)) == count_q);
	assign ram_we     = accept && (in_action == ACT_LOAD) && !table_full;

	// The output register is free once the pending result is taken.
	assign out_load   = (state_q == ST_FIN) && (!m_tvalid_q || m_tready);

	itl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_INTERVALS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[AW-1:0]),
		.wdata (in_entry),
		.raddr (addr_q),
		.rdata (rd_data)
	);

	assign rd_entry = entry_t'(rd_data);

	itl_cmp_unit u_cmp (
		.entry      (rd_entry),
		.best       (best_q),
		.best_found (found_q),
		.query_time (t_q),
		.res        (cmp_res)
	);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q <= '0;
		end else if (cfg_we) begin
			default_q <= cfg_wdata;
		end
	end

	// Table bookkeeping and the scan sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			inv_q       <= 1'b0;
			ovf_q       <= 1'b0;
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			// Read data lags the address by the RAM read register.
			rd_valid_s1 <= (state_q == ST_SCAN);
			if (rd_valid_s1 && cmp_res.take) begin
				found_q <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_action)
							ACT_CLEAR: begin
								count_q <= '0;
								inv_q   <= 1'b0;
								ovf_q   <= 1'b0;
							end
							ACT_LOAD: begin
								if ($signed(in_entry.end_time) <
									$signed(in_entry.start_time)) begin
									inv_q <= 1'b1;
								end
								if (table_full) begin
									ovf_q <= 1'b1;
								end else begin
									count_q <= count_q + CW'(1);
								end
							end
							ACT_QUERY: begin
								found_q <= 1'b0;
								addr_q  <= '0;
								// An invalid load or an empty table needs no scan.
								if (inv_q || (count_q == '0)) begin
									state_q <= ST_FIN;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							default: begin
								// The unused kind is taken and dropped.
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (last_addr) begin
						state_q <= ST_LAST;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_LAST: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Query time and the best entry so far are payload only.
	always_ff @(posedge clk) begin
		if (accept && (in_action == ACT_QUERY)) begin
			t_q <= in_query_time;
		end
		if (rd_valid_s1 && cmp_res.take) begin
			best_q <= rd_entry;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_label_q   <= found_q ? best_q.label : default_q;
			m_covered_q <= found_q;
			if (inv_q) begin
				m_status_q <= STAT_INVALID;
			end else if (ovf_q) begin
				m_status_q <= STAT_OVERFLOW;
			end else begin
				m_status_q <= STAT_OK;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_label_q;
	assign m_tuser  = {m_status_q, m_covered_q};

	// The scan never addresses past the stored entries.
	`ITL_ASSERT(a_scan_in_table, (state_q == ST_SCAN) |-> (CW'(addr_q) < count_q))
	// Read data only arrives while the scan or its last compare is running.
	`ITL_ASSERT(a_rd_in_scan, rd_valid_s1 |-> (state_q == ST_SCAN || state_q == ST_LAST))
	// The fill count never passes the table depth.
	`ITL_ASSERT(a_count_bound, count_q <= CW'(MAX_INTERVALS))
	// A covered result never comes from a query that saw an invalid interval.
	`ITL_ASSERT(a_covered_valid, out_load |=> !(m_covered_q && (m_status_q == STAT_INVALID)))
	// A clock edge under reset parks the sequencer and empties the output register.
	`ITL_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> (state_q == ST_IDLE && !m_tvalid_q))

endmodule

// File: hw/rtl/itl_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module itl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: hw/rtl/itl_cmp_unit.sv
// ----------------------------------------------------------------------------
// Interval compare unit
// Checks one table entry for coverage of the query time and ranks it
// against the best entry found so far.
// ----------------------------------------------------------------------------
module itl_cmp_unit (
	input  itl_pkg::entry_t                 entry,
	input  itl_pkg::entry_t                 best,
	input  logic                            best_found,
	input  logic [itl_pkg::TIME_W-1:0]      query_time,
	output itl_pkg::cmp_res_t               res
);

	import itl_pkg::*;

	logic [ENTRY_W-1:0] entry_key;
	logic [ENTRY_W-1:0] best_key;
	logic [TIME_W-1:0]  t_key;

	// Flipping the sign bits turns signed lexicographic order into unsigned order.
	assign entry_key = {entry.start_time ^ SIGN_TIME, entry.end_time ^ SIGN_TIME,
		entry.label ^ SIGN_LABEL};
	assign best_key  = {best.start_time ^ SIGN_TIME, best.end_time ^ SIGN_TIME,
		best.label ^ SIGN_LABEL};
	assign t_key     = query_time ^ SIGN_TIME;

	always_comb begin
		res.covers  = ((entry.start_time ^ SIGN_TIME) <= t_key) &&
			(t_key < (entry.end_time ^ SIGN_TIME));
		res.greater = entry_key > best_key;
		res.take    = res.covers && (!best_found || res.greater);
	end

endmodule
